[sv/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int DEFAULT_MAX_PROCESSES = 16;

    localparam int SLOT_W  = 4;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 24;
    localparam int COUNT_W = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // load data broadcast to the cells
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } pps_load_t;

    // per-cycle control broadcast to the cells
    typedef struct packed {
        logic               dec_en;
        logic [SLOT_W-1:0]  dec_slot;
        logic [TIME_W-1:0]  cur_time;
        logic [COUNT_W-1:0] count;
    } pps_bcast_t;

    // best candidate so far, handed cell to cell
    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               last;
    } pps_token_t;

    localparam pps_token_t TOKEN_NONE = '0;

endpackage

[sv/pps_cell.sv]
// ----------------------------------------------------------------------------
// pps_cell
// One process slot: holds its parameters and remaining time, and merges
// itself into the candidate token passed down the chain.
// ----------------------------------------------------------------------------
module pps_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  pps_pkg::pps_load_t  ld,
    input  pps_pkg::pps_bcast_t ctl,
    input  pps_pkg::pps_token_t tok_in,
    output pps_pkg::pps_token_t tok_out,
    output logic               pending
);
    import pps_pkg::*;

    logic [ARR_W-1:0]   arrival_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [BURST_W-1:0] remain_reg;
    logic [BURST_W-1:0] remain_next;
    logic [BURST_W-1:0] burst_fix;
    pps_token_t         tok_reg;
    pps_token_t         tok_next;
    logic               active;
    logic               eligible;
    logic               take;

    assign burst_fix = (ld.burst == '0) ? BURST_W'(1) : ld.burst;
    assign active    = int'(ctl.count) > CELL_INDEX;
    assign pending   = active && (remain_reg != '0);
    assign eligible  = pending && (TIME_W'(arrival_reg) <= ctl.cur_time);
    assign take      = eligible && (!tok_in.found || (prio_reg < tok_in.prio));

    always_comb
    begin
        remain_next = remain_reg;
        if (wr_en)
        begin
            remain_next = burst_fix;
        end
        else if (ctl.dec_en && (int'(ctl.dec_slot) == CELL_INDEX) && (remain_reg != '0))
        begin
            remain_next = remain_reg - BURST_W'(1);
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found   = 1'b1;
            tok_next.slot    = SLOT_W'(CELL_INDEX);
            tok_next.prio    = prio_reg;
            tok_next.arrival = arrival_reg;
            tok_next.burst   = burst_reg;
            tok_next.last    = (remain_reg == BURST_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            tok_reg    <= TOKEN_NONE;
        end
        else
        begin
            remain_reg <= remain_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            arrival_reg <= ld.arrival;
            burst_reg   <= burst_fix;
            prio_reg    <= ld.prio;
        end
    end

    assign tok_out = tok_reg;

endmodule

[sv/preemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler, one time unit per tick transaction.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | operation slot arrival_time burst_time
//           |                    | priority_req
//   out     | out_valid/out_stall| served_slot idle finished finish_time
//           |                    | turnaround waiting all_done
//   cfg     | cfg_we             | cfg_wdata (process_count)
//
// A load writes its slot without stalling the input. In a tick, the
// candidate token walks the cell chain one cell per cycle, then the
// update state and result state. in_stall is high while a tick is in flight.
// The output register holds a result under out_stall; the next transaction
// is taken meanwhile. Reset leaves all slots empty, time at 0, count at 1.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
    parameter int MAX_PROCESSES = pps_pkg::DEFAULT_MAX_PROCESSES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [pps_pkg::SLOT_W-1:0]   slot,
    input  logic [pps_pkg::ARR_W-1:0]    arrival_time,
    input  logic [pps_pkg::BURST_W-1:0]  burst_time,
    input  logic [pps_pkg::PRIO_W-1:0]   priority_req,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pps_pkg::SLOT_W-1:0]   served_slot,
    output logic                         idle,
    output logic                         finished,
    output logic [pps_pkg::TIME_W-1:0]   finish_time,
    output logic [pps_pkg::TIME_W-1:0]   turnaround,
    output logic [pps_pkg::TIME_W-1:0]   waiting,
    output logic                         all_done,
    input  logic                         cfg_we,
    input  logic [pps_pkg::COUNT_W-1:0]  cfg_wdata
);
    import pps_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCESSES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  time_reg, time_next;

    logic               u_found_reg;
    logic [SLOT_W-1:0]  u_slot_reg;
    logic               u_fin_reg;
    logic [TIME_W-1:0]  u_time_reg;
    logic [TIME_W-1:0]  u_tat_reg;
    logic [BURST_W-1:0] u_burst_reg;

    logic               out_valid_reg;
    logic [SLOT_W-1:0]  served_reg;
    logic               idle_reg;
    logic               fin_reg;
    logic [TIME_W-1:0]  ftime_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [TIME_W-1:0]  wt_reg;
    logic               done_reg;

    logic               in_fire;
    logic               load_fire;
    logic               tick_fire;
    logic               out_free;
    logic [TIME_W-1:0]  time_inc;
    logic [TIME_W-1:0]  wt_calc;

    pps_load_t          ld;
    pps_bcast_t         ctl;
    pps_token_t         tok [MAX_PROCESSES];
    pps_token_t         tail;
    logic [MAX_PROCESSES-1:0] pend;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign load_fire = in_fire && (operation == OP_LOAD);
    assign tick_fire = in_fire && (operation == OP_TICK);
    assign out_free  = !out_valid_reg || !out_stall;
    assign tail      = tok[MAX_PROCESSES-1];
    assign time_inc  = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
    assign wt_calc   = (u_tat_reg > TIME_W'(u_burst_reg)) ?
                       u_tat_reg - TIME_W'(u_burst_reg) : '0;

    assign ld.arrival = arrival_time;
    assign ld.burst   = burst_time;
    assign ld.prio    = priority_req;

    assign ctl.dec_en   = (state_reg == ST_UPDATE) && tail.found;
    assign ctl.dec_slot = tail.slot;
    assign ctl.cur_time = time_reg;
    assign ctl.count    = count_reg;

    for (genvar i = 0; i < MAX_PROCESSES; i++)
    begin : g_cell
        pps_token_t tin;
        if (i == 0)
        begin : g_head
            assign tin = TOKEN_NONE;
        end
        else
        begin : g_link
            assign tin = tok[i-1];
        end
        pps_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (load_fire && (int'(slot) == i)),
            .ld      (ld),
            .ctl     (ctl),
            .tok_in  (tin),
            .tok_out (tok[i]),
            .pending (pend[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        time_next  = time_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (load_fire)
                begin
                    time_next = '0;
                end
                if (tick_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_PROCESSES - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                time_next  = time_inc;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            count_reg     <= COUNT_W'(1);
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            time_reg  <= time_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if ((state_reg == ST_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            u_found_reg <= tail.found;
            u_slot_reg  <= tail.found ? tail.slot : '0;
            u_fin_reg   <= tail.found && tail.last;
            u_time_reg  <= time_inc;
            u_tat_reg   <= (tail.found && tail.last) ? time_inc - TIME_W'(tail.arrival) : '0;
            u_burst_reg <= tail.burst;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            served_reg <= u_slot_reg;
            idle_reg   <= !u_found_reg;
            fin_reg    <= u_fin_reg;
            ftime_reg  <= u_time_reg;
            tat_reg    <= u_tat_reg;
            wt_reg     <= u_fin_reg ? wt_calc : '0;
            done_reg   <= ~|pend;
        end
    end

    assign out_valid   = out_valid_reg;
    assign served_slot = served_reg;
    assign idle        = idle_reg;
    assign finished    = fin_reg;
    assign finish_time = ftime_reg;
    assign turnaround  = tat_reg;
    assign waiting     = wt_reg;
    assign all_done    = done_reg;

endmodule

[sv/pps_checker.sv]
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
module pps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         operation,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [pps_pkg::SLOT_W-1:0]   served_slot,
    input logic                         idle,
    input logic                         finished,
    input logic [pps_pkg::TIME_W-1:0]   finish_time,
    input logic [pps_pkg::TIME_W-1:0]   turnaround,
    input logic [pps_pkg::TIME_W-1:0]   waiting,
    input logic                         all_done
);
    import pps_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(served_slot) && $stable(finish_time)
        && $stable(all_done))
        else $error("result changed while stalled");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (operation == OP_TICK) |=> in_stall)
        else $error("input not stalled during tick");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && idle |-> (served_slot == '0) && !finished)
        else $error("idle result carries a slot");

    a_no_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished |-> (turnaround == '0) && (waiting == '0))
        else $error("times reported without completion");

    a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> waiting <= turnaround)
        else $error("waiting exceeds turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
